[hw/rtl/kwm_pkg.sv]
// ----------------------------------------------------------------------------
// kwm_pkg
// shared constants, types and helper functions of the k-way merge block
// ----------------------------------------------------------------------------
package kwm_pkg;

  localparam int MAX_RUNS   = 8;
  localparam int RUN_W      = 3;
  localparam int CNT_W      = 4;
  localparam int ELEM_BYTES = 8;
  localparam int ELEM_W     = 64;

  localparam int IN_TDATA_W  = 72;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 72;
  localparam int OUT_TUSER_W = 4;

  // run status codes
  localparam logic [1:0] RS_WAIT = 2'd0;
  localparam logic [1:0] RS_HOLD = 2'd1;
  localparam logic [1:0] RS_DONE = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_NUM_RUNS  = 2'd0;
  localparam logic [1:0] CFG_DEDUPE    = 2'd1;
  localparam logic [1:0] CFG_KEY_START = 2'd2;
  localparam logic [1:0] CFG_KEY_SIZE  = 2'd3;

  localparam logic [7:0] BYTE_ONES = 8'd255;

  // controller to datapath
  typedef struct packed {
    logic             take;
    logic             scan_en;
    logic [RUN_W-1:0] idx;
    logic             commit;
  } kwm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_full;
  } kwm_sts_t;

  // clamp the run count to 1..MAX_RUNS
  function automatic logic [CNT_W-1:0] active_runs(input logic [CNT_W-1:0] num);
    logic [CNT_W-1:0] n;
    n = num;
    if (n == '0) n = CNT_W'(1);
    if (n > CNT_W'(MAX_RUNS)) n = CNT_W'(MAX_RUNS);
    return n;
  endfunction

  // bit mask of the key bytes; masked elements compare like extracted keys
  function automatic logic [ELEM_W-1:0] key_mask(input logic [2:0] ks,
                                                 input logic [3:0] ksz);
    logic [ELEM_W-1:0] m;
    logic [4:0]        kend;
    m    = '0;
    kend = 5'(ks) + 5'(ksz);
    for (int i = 0; i < ELEM_BYTES; i++) begin
      if ((5'(i) >= 5'(ks)) && (5'(i) < kend)) begin
        m[8*(ELEM_BYTES-1-i) +: 8] = BYTE_ONES;
      end
    end
    return m;
  endfunction

endpackage

[hw/rtl/kwm_ctrl.sv]
// ----------------------------------------------------------------------------
// kwm_ctrl
// sequencer: take a word, scan the run slots one a cycle, commit the result
// ----------------------------------------------------------------------------
module kwm_ctrl
  import kwm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CNT_W-1:0] n_runs,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  kwm_sts_t         sts,
  output kwm_cmd_t         cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [RUN_W-1:0] idx_r, idx_nxt;
  logic             scan_last;

  assign scan_last = ({1'b0, idx_r} == (n_runs - CNT_W'(1)));
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    cmd.take    = 1'b0;
    cmd.scan_en = 1'b0;
    cmd.idx     = idx_r;
    cmd.commit  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.take  = 1'b1;
          idx_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_en = 1'b1;
        if (scan_last) begin
          state_nxt = S_COMMIT;
        end else begin
          idx_nxt = idx_r + RUN_W'(1);
        end
      end
      S_COMMIT: begin
        if (!sts.out_full) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  a_take_to_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take |=> (state_r == S_SCAN) && (idx_r == '0))
    else $error("scan did not start after a taken word");

  a_scan_to_commit: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.scan_en && scan_last) |=> (state_r == S_COMMIT))
    else $error("scan end did not lead to commit");

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_en |-> ({1'b0, cmd.idx} < n_runs))
    else $error("scan index past run count");

endmodule

[hw/rtl/kwm_datapath.sv]
// ----------------------------------------------------------------------------
// kwm_datapath
// run heads and status, minimum scan with one key comparator, output register
// ----------------------------------------------------------------------------
module kwm_datapath
  import kwm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  kwm_cmd_t               cmd,
  output kwm_sts_t               sts,
  input  logic [CNT_W-1:0]       n_runs,
  input  logic                   remove_dupes,
  input  logic [ELEM_W-1:0]      mask,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [OUT_TUSER_W-1:0] out_tuser
);

  logic [ELEM_W-1:0] heads_r [MAX_RUNS];
  logic [1:0]        status_r [MAX_RUNS];

  logic [ELEM_W-1:0] last_r;
  logic              has_last_r;
  logic              rej_r;

  // scan accumulators
  logic              wait_found_r;
  logic [RUN_W-1:0]  first_wait_r;
  logic              best_found_r;
  logic [RUN_W-1:0]  best_sel_r;
  logic [ELEM_W-1:0] best_key_r;
  logic [ELEM_W-1:0] best_elem_r;

  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic [OUT_TUSER_W-1:0] out_tuser_r;
  logic [OUT_TDATA_W-1:0] out_tdata_nxt;
  logic [OUT_TUSER_W-1:0] out_tuser_nxt;

  logic [RUN_W-1:0]  in_run;
  logic [ELEM_W-1:0] in_elem;
  logic              in_empty;
  logic              in_rej;

  logic [ELEM_W-1:0] scan_elem;
  logic [1:0]        scan_st;
  logic [ELEM_W-1:0] scan_key;
  logic              take_best;

  logic              c_emit;
  logic              c_fin;
  logic              dup_hit;

  assign in_run   = in_tdata[RUN_W-1:0];
  assign in_elem  = in_tdata[RUN_W +: ELEM_W];
  assign in_empty = in_tuser[0];
  assign in_rej   = ({1'b0, in_run} >= n_runs) || (status_r[in_run] != RS_WAIT);

  assign scan_elem = heads_r[cmd.idx];
  assign scan_st   = status_r[cmd.idx];
  assign scan_key  = scan_elem & mask;
  assign take_best = (scan_st == RS_HOLD) && (!best_found_r || (scan_key <= best_key_r));

  assign dup_hit = remove_dupes && has_last_r && ((last_r & mask) == best_key_r);
  assign c_fin   = !wait_found_r && !best_found_r;
  assign c_emit  = !wait_found_r && best_found_r && !dup_hit;

  assign sts.out_full = out_valid_r && !out_tready;

  // head store, no reset
  always_ff @(posedge clk) begin
    if (cmd.take && !in_rej && !in_empty) begin
      heads_r[in_run] <= in_elem;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_RUNS; i++) status_r[i] <= RS_WAIT;
      has_last_r <= 1'b0;
      last_r     <= '0;
    end else if (cmd.take) begin
      if (!in_rej) begin
        status_r[in_run] <= in_empty ? RS_DONE : RS_HOLD;
      end
    end else if (cmd.commit && !wait_found_r) begin
      if (c_fin) begin
        for (int i = 0; i < MAX_RUNS; i++) status_r[i] <= RS_WAIT;
        has_last_r <= 1'b0;
      end else begin
        status_r[best_sel_r] <= RS_WAIT;
        if (c_emit) begin
          last_r     <= best_elem_r;
          has_last_r <= 1'b1;
        end
      end
    end
  end

  // scan accumulators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wait_found_r <= 1'b0;
      best_found_r <= 1'b0;
      rej_r        <= 1'b0;
    end else if (cmd.take) begin
      wait_found_r <= 1'b0;
      best_found_r <= 1'b0;
      rej_r        <= in_rej;
    end else if (cmd.scan_en) begin
      if ((scan_st == RS_WAIT) && !wait_found_r) begin
        wait_found_r <= 1'b1;
      end
      if (take_best) begin
        best_found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      first_wait_r <= '0;
      best_sel_r   <= '0;
      best_key_r   <= '0;
      best_elem_r  <= '0;
    end else if (cmd.scan_en) begin
      if ((scan_st == RS_WAIT) && !wait_found_r) begin
        first_wait_r <= cmd.idx;
      end
      if (take_best) begin
        best_sel_r  <= cmd.idx;
        best_key_r  <= scan_key;
        best_elem_r <= scan_elem;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result word built from the scan outcome
  always_comb begin
    out_tdata_nxt    = '0;
    out_tuser_nxt    = '0;
    out_tuser_nxt[1] = 1'b1;
    out_tuser_nxt[3] = rej_r;
    if (wait_found_r) begin
      out_tdata_nxt[ELEM_W +: RUN_W] = first_wait_r;
    end else if (c_fin) begin
      out_tuser_nxt[2] = 1'b1;
    end else begin
      out_tdata_nxt[ELEM_W-1:0]      = best_elem_r;
      out_tdata_nxt[ELEM_W +: RUN_W] = best_sel_r;
      out_tuser_nxt[0]               = c_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_tdata_r <= out_tdata_nxt;
      out_tuser_r <= out_tuser_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !(out_valid_r && !out_tready))
    else $error("commit over an untaken word");

  a_emit_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_tuser_r[0]) |-> (out_tuser_r[1] && !out_tuser_r[2]))
    else $error("emitted word with bad flags");

  a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && c_fin) |=> (status_r[0] == RS_WAIT) && !has_last_r)
    else $error("finish did not reset the merge");

endmodule

[hw/rtl/kway_merge_with_dedupe.sv]
// ----------------------------------------------------------------------------
// kway_merge_with_dedupe
// k-way merge of up to eight sorted runs with optional duplicate removal
// ----------------------------------------------------------------------------
// Each input word answers the run the block asked for with that run's next
// element or an end mark; each input word gives exactly one output word. The
// output word either asks for a run still waiting for its head (the lowest
// one), or reports finished when every run is done, or carries the head with
// the smallest key (higher run wins ties) and asks that run again; with
// dedupe on, a head whose key equals the last emitted key is shown but not
// flagged emitted. After a word is taken, the run slots up to the active run
// count (num_runs held to 1..8) are scanned in turn through the head store
// with a single key comparator, and then the output register is loaded;
// that load waits as long as the output register still holds an untaken
// word. A result waiting in the output register does not hold off taking
// the next input word.
// ----------------------------------------------------------------------------
module kway_merge_with_dedupe
  import kwm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration write port
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [3:0]             cfg_data,
  // input words
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // run_index[2:0], element[66:3], pad
  input  logic [IN_TUSER_W-1:0]  in_tuser,   // run_empty[0]
  // output words
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // out_element[63:0], want_run[66:64], pad
  output logic [OUT_TUSER_W-1:0] out_tuser   // emitted, want_valid, finished, rejected
);

  logic [3:0] num_runs_r;
  logic       remove_dupes_r;
  logic [2:0] key_start_r;
  logic [3:0] key_size_r;

  logic [CNT_W-1:0]  n_runs;
  logic [ELEM_W-1:0] mask;
  kwm_cmd_t          cmd;
  kwm_sts_t          sts;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_runs_r     <= 4'd2;
      remove_dupes_r <= 1'b0;
      key_start_r    <= 3'd0;
      key_size_r     <= 4'd8;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NUM_RUNS:  num_runs_r     <= cfg_data;
        CFG_DEDUPE:    remove_dupes_r <= cfg_data[0];
        CFG_KEY_START: key_start_r    <= cfg_data[2:0];
        CFG_KEY_SIZE:  key_size_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamped run count, key byte mask; user keeps static while a merge runs, unenforced
  assign n_runs = active_runs(num_runs_r);
  assign mask   = key_mask(key_start_r, key_size_r);

  kwm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .n_runs    (n_runs),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  kwm_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .n_runs       (n_runs),
    .remove_dupes (remove_dupes_r),
    .mask         (mask),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser)
  );

endmodule
